>>> rtl/core/kmds_pkg.sv
// ----------------------------------------------------------------------------
// kmds_pkg
// Shared widths and constants for the key matrix debounce scanner.
// ----------------------------------------------------------------------------
package kmds_pkg;

	// row sample fields
	localparam int ROW_IN_W      = 3;
	localparam int INPUT_COLUMNS = 8;
	localparam int S_DATA_W      = 16;

	// key event fields
	localparam int KEY_W    = 6;
	localparam int M_DATA_W = 8;

	// debounce threshold register
	localparam int              TICKS_W     = 7;
	localparam logic [TICKS_W-1:0] TICKS_RESET = 7'd5;

endpackage

>>> rtl/core/kmds_lane.sv
// ----------------------------------------------------------------------------
// kmds_lane
// Debounce core for one matrix column: level and mismatch count per row.
// ----------------------------------------------------------------------------
module kmds_lane import kmds_pkg::*; #(
	parameter int ROW_COUNT    = 8,
	parameter int COLUMN_COUNT = 8,
	parameter int KEY_COUNT    = 64,
	parameter int COL          = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [ROW_IN_W-1:0] row,
	input  logic                sample,
	input  logic [TICKS_W-1:0]  ticks,
	output logic                hit,
	output logic                pressed
);

	localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	logic                level_q [ROW_COUNT];
	logic [TICKS_W-1:0]  count_q [ROW_COUNT];
	logic [ROW_W-1:0]    row_sel;
	logic                key_ok;
	logic                upd;
	logic                lvl;
	logic [TICKS_W-1:0]  cnt;
	logic [TICKS_W-1:0]  cnt_inc;
	logic                differ;
	logic                flip;

	// read the state of the addressed key
	always_comb begin
		row_sel = ROW_W'(row);
		key_ok  = (int'(row) * COLUMN_COUNT + COL) < KEY_COUNT;
		upd     = en && key_ok;
		lvl     = level_q[row_sel];
		cnt     = count_q[row_sel];
		cnt_inc = cnt + 1'b1;
		differ  = sample != lvl;
		flip    = differ && (cnt_inc >= ticks);
		hit     = upd && flip;
		pressed = sample;
	end

	// state update, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROW_COUNT; r++) begin
				level_q[r] <= 1'b0;
				count_q[r] <= '0;
			end
		end else if (upd) begin
			if (flip) begin
				level_q[row_sel] <= sample;
				count_q[row_sel] <= '0;
			end else if (differ) begin
				count_q[row_sel] <= cnt_inc;
			end else begin
				count_q[row_sel] <= '0;
			end
		end
	end

endmodule

>>> rtl/core/kmds_merge.sv
// ----------------------------------------------------------------------------
// kmds_merge
// Collects lane events of one row and sends one item per cycle if not stalled.
// ----------------------------------------------------------------------------
module kmds_merge import kmds_pkg::*; #(
	parameter int COLUMN_COUNT = 8,
	parameter int LANES        = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [ROW_IN_W-1:0] load_row,
	input  logic [LANES-1:0]    load_mask,
	input  logic [LANES-1:0]    load_lvl,
	output logic                load_ready,
	output logic                m_valid,
	input  logic                m_ready,
	output logic [KEY_W-1:0]    m_key,
	output logic                m_pressed,
	output logic                m_last
);

	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic                s1_valid_q;
	logic [ROW_IN_W-1:0] row_s1;
	logic [LANES-1:0]    mask_s1;
	logic [LANES-1:0]    lvl_s1;
	logic [LANES-1:0]    pend_q;
	logic [ROW_IN_W-1:0] row_q;
	logic [LANES-1:0]    lvl_q;
	logic [LANES-1:0]    rest;
	logic [IDX_W-1:0]    idx;
	logic                pop;
	logic                pend_free;
	logic                move;

	// lowest pending column goes out first
	always_comb begin
		idx = '0;
		for (int c = LANES - 1; c >= 0; c--) begin
			if (pend_q[c]) begin
				idx = IDX_W'(c);
			end
		end
		rest       = pend_q & (pend_q - 1'b1);
		m_valid    = pend_q != '0;
		m_last     = rest == '0;
		m_pressed  = lvl_q[idx];
		m_key      = KEY_W'(int'(row_q) * COLUMN_COUNT + int'(idx));
		pop        = m_valid && m_ready;
		pend_free  = !m_valid || (pop && m_last);
		move       = s1_valid_q && pend_free;
		load_ready = !s1_valid_q || pend_free;
	end

	// skid stage between lanes and the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (load && load_ready && (load_mask != '0)) begin
			s1_valid_q <= 1'b1;
		end else if (move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ready) begin
			row_s1  <= load_row;
			mask_s1 <= load_mask;
			lvl_s1  <= load_lvl;
		end
	end

	// pending event mask of the row being sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (move) begin
			pend_q <= mask_s1;
		end else if (pop) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			row_q <= row_s1;
			lvl_q <= lvl_s1;
		end
	end

endmodule

>>> rtl/core/key_matrix_debounce_scanner.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner
// Key matrix scanner with per-key counter debounce and serial key events.
// ----------------------------------------------------------------------------
// Each input item is one sampled matrix row. All columns of the row are
// debounced in parallel lanes in the cycle the item is accepted, so the key
// state is updated at once and a row item can be taken every cycle unless
// events are waiting. The key events of a row (at most one per column, up to
// eight) leave through a skid stage and an output register one item per clock
// when not stalled, lowest column first, with tlast on the final one; a row
// with none produces nothing. Sustained rate is therefore set by the event
// serializer. The key state lives in flip-flops and is cleared by reset
// directly, with no clearing pass. The debounce threshold resets to 5 and may
// only be written while the block is idle.
// ----------------------------------------------------------------------------
module key_matrix_debounce_scanner import kmds_pkg::*; #(
	parameter int ROW_COUNT    = 8,
	parameter int COLUMN_COUNT = 8,
	parameter int KEY_COUNT    = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// row sample items
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // row_index[2:0], column_levels[10:3]
	// key event items
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,  // key_code[5:0], pressed[6]
	output logic                m_axis_tlast,  // last_event
	// debounce threshold
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [TICKS_W-1:0]  cfg_data       // debounce_ticks
);

	localparam int LANES = (COLUMN_COUNT < INPUT_COLUMNS) ? COLUMN_COUNT : INPUT_COLUMNS;

	logic [TICKS_W-1:0]       ticks_q;
	logic [ROW_IN_W-1:0]      row_index;
	logic [INPUT_COLUMNS-1:0] column_levels;
	logic                     accept;
	logic                     row_ok;
	logic [LANES-1:0]         hit;
	logic [LANES-1:0]         lvl;
	logic [KEY_W-1:0]         key_code;
	logic                     pressed;

	// threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ticks_q <= cfg_data;
		end
	end

	// unpack the row item
	always_comb begin
		row_index     = s_axis_tdata[ROW_IN_W-1:0];
		column_levels = s_axis_tdata[ROW_IN_W +: INPUT_COLUMNS];
		accept        = s_axis_tvalid && s_axis_tready;
		row_ok        = int'(row_index) < ROW_COUNT;
	end

	// one debounce lane per sampled column
	for (genvar c = 0; c < LANES; c++) begin : g_lane
		kmds_lane #(
			.ROW_COUNT    (ROW_COUNT),
			.COLUMN_COUNT (COLUMN_COUNT),
			.KEY_COUNT    (KEY_COUNT),
			.COL          (c)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (accept && row_ok),
			.row     (row_index),
			.sample  (!column_levels[c]),
			.ticks   (ticks_q),
			.hit     (hit[c]),
			.pressed (lvl[c])
		);
	end

	// serialize the events of each row
	kmds_merge #(
		.COLUMN_COUNT (COLUMN_COUNT),
		.LANES        (LANES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s_axis_tvalid),
		.load_row   (row_index),
		.load_mask  (hit),
		.load_lvl   (lvl),
		.load_ready (s_axis_tready),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_key      (key_code),
		.m_pressed  (pressed),
		.m_last     (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, pressed, key_code};

endmodule

>>> rtl/core/kmds_checker.sv
// ----------------------------------------------------------------------------
// kmds_checker
// Port-level checks for the key matrix debounce scanner.
// ----------------------------------------------------------------------------
module kmds_checker import kmds_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [M_DATA_W-1:0] m_axis_tdata,
	input logic                m_axis_tlast
);

	// a stalled event item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("event item changed while stalled");

	// events of one row follow without a gap
	a_row_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a row's events");

	// events of one row carry distinct keys
	a_key_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tdata[KEY_W-1:0] != $past(m_axis_tdata[KEY_W-1:0]))
		else $error("repeated key within a row");

	// input only stalls behind a waiting event
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with output idle");

endmodule

bind key_matrix_debounce_scanner kmds_checker u_kmds_checker (.*);

>>> test/key_matrix_debounce_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_test
// Self-checking bench for the key matrix debounce scanner.
// ----------------------------------------------------------------------------
// Row samples go in over the slave stream and key events are checked as they
// leave the master stream. A scoreboard object keeps its own copy of every
// key's debounced level and disagreement count, predicts the events of each
// accepted row and compares them in order. Directed rows cover the default,
// zero, one, maximum and lowered thresholds; scan-like random rows with held
// patterns and noise follow, with random stalls on both streams.
// ----------------------------------------------------------------------------

import kmds_pkg::*;

typedef struct packed {
	logic [KEY_W-1:0] key_code;
	logic             pressed;
	logic             last_event;
} key_event_t;

class key_event_board #(int ROWS = 8, int COLS = 8, int KEYS = 64);
	bit               level [KEYS];
	bit [TICKS_W-1:0] disagree [KEYS];
	bit [TICKS_W-1:0] ticks;
	key_event_t       expected_events [$];
	int               failures;

	function new();
		foreach (level[k]) begin
			level[k]    = 1'b0;
			disagree[k] = '0;
		end
		ticks    = TICKS_RESET;
		failures = 0;
	endfunction

	function void set_ticks(bit [TICKS_W-1:0] value);
		ticks = value;
	endfunction

	function int pending();
		return expected_events.size();
	endfunction

	// debounce one accepted row and queue the key events it causes
	function void note_row(bit [ROW_IN_W-1:0] row, bit [INPUT_COLUMNS-1:0] cols);
		key_event_t       row_events [$];
		key_event_t       ev;
		int unsigned      code;
		bit               sample;
		bit [TICKS_W-1:0] cnt;
		if (row >= ROWS)
			return;
		for (int col = 0; col < COLS; col++) begin
			code = row * COLS + col;
			if (code >= KEYS)
				continue;
			// columns without an input bit read as released
			sample = (col < INPUT_COLUMNS) ? ~cols[col] : 1'b0;
			if (sample != level[code]) begin
				cnt = disagree[code] + 1'b1;
				if (cnt >= ticks) begin
					level[code]    = sample;
					disagree[code] = '0;
					if (row_events.size() < 8) begin
						ev.key_code   = code[KEY_W-1:0];
						ev.pressed    = sample;
						ev.last_event = 1'b0;
						row_events.push_back(ev);
					end
				end else begin
					disagree[code] = cnt;
				end
			end else begin
				disagree[code] = '0;
			end
		end
		if (row_events.size() > 0)
			row_events[row_events.size()-1].last_event = 1'b1;
		foreach (row_events[i])
			expected_events.push_back(row_events[i]);
	endfunction

	// compare one accepted key event with the oldest prediction
	function void check_event(logic [KEY_W-1:0] code, logic pressed, logic last_event);
		key_event_t ev;
		if (expected_events.size() == 0) begin
			$error("unexpected key event: key_code %0d pressed %0d last_event %0d",
				code, pressed, last_event);
			failures++;
			return;
		end
		ev = expected_events.pop_front();
		if (code !== ev.key_code) begin
			$error("key_code mismatch: expected %0d, actual %0d", ev.key_code, code);
			failures++;
		end
		if (pressed !== ev.pressed) begin
			$error("pressed mismatch: expected %0d, actual %0d", ev.pressed, pressed);
			failures++;
		end
		if (last_event !== ev.last_event) begin
			$error("last_event mismatch: expected %0d, actual %0d",
				ev.last_event, last_event);
			failures++;
		end
	endfunction
endclass

module key_matrix_debounce_scanner_test;

	localparam int ROW_COUNT    = 8;
	localparam int COLUMN_COUNT = 8;
	localparam int KEY_COUNT    = 64;
	localparam int HOLD_OFF     = 8;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata;   // row_index[2:0], column_levels[10:3]
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;   // key_code[5:0], pressed[6]
	logic                m_axis_tlast;   // last_event
	logic                cfg_valid;
	logic                cfg_ready;
	logic [TICKS_W-1:0]  cfg_data;       // debounce_ticks

	key_event_board #(ROW_COUNT, COLUMN_COUNT, KEY_COUNT) board;

	bit                       idle_on;
	int                       rx_stall;
	logic [INPUT_COLUMNS-1:0] held [ROW_COUNT];

	key_matrix_debounce_scanner #(
		.ROW_COUNT    (ROW_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT),
		.KEY_COUNT    (KEY_COUNT)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// key event receiver with random stall bursts
	initial begin
		m_axis_tready = 1'b0;
		rx_stall      = 0;
		@(posedge arst_n);
		forever @(negedge clk) begin
			if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rx_stall = $urandom_range(1, 9) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// key event monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_event(m_axis_tdata[KEY_W-1:0], m_axis_tdata[KEY_W], m_axis_tlast);
	end

	// send one row item, entered and left at a falling edge
	task automatic send_row(input logic [ROW_IN_W-1:0] row,
			input logic [INPUT_COLUMNS-1:0] cols);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_DATA_W-ROW_IN_W-INPUT_COLUMNS){1'b0}}, cols, row};
		do @(posedge clk); while (!s_axis_tready);
		board.note_row(row, cols);
		@(negedge clk);
	endtask

	task automatic repeat_row(input logic [ROW_IN_W-1:0] row,
			input logic [INPUT_COLUMNS-1:0] cols, input int count);
		repeat (count) send_row(row, cols);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
	endtask

	// threshold write, only once the block has gone quiet
	task automatic write_ticks(input logic [TICKS_W-1:0] value);
		wait_drained();
		repeat (HOLD_OFF) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_ticks(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// scan-like rows: held patterns per row with noise and occasional changes
	task automatic scan_rows(input int count, input bit pause_midway);
		logic [ROW_IN_W-1:0]      row;
		logic [INPUT_COLUMNS-1:0] cols;
		int                       pick;
		row = ROW_IN_W'($urandom_range(0, ROW_COUNT - 1));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0)
				row = ROW_IN_W'($urandom_range(0, ROW_COUNT - 1));
			else
				row = ROW_IN_W'((row + 1) % ROW_COUNT);
			pick = $urandom_range(0, 15);
			if (pick == 0)
				cols = INPUT_COLUMNS'($urandom);
			else if (pick < 3)
				cols = held[row] ^ (8'h01 << $urandom_range(0, INPUT_COLUMNS - 1));
			else
				cols = held[row];
			send_row(row, cols);
			// a key pressed or released, or a whole new pattern
			pick = $urandom_range(0, 11);
			if (pick == 0)
				held[row] = INPUT_COLUMNS'($urandom);
			else if (pick == 1)
				held[row] ^= 8'h01 << $urandom_range(0, INPUT_COLUMNS - 1);
			if (pause_midway && i == count / 2)
				wait_drained();
		end
	endtask

	// main sequence
	initial begin
		board         = new();
		idle_on       = 1'b1;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		foreach (held[r])
			held[r] = INPUT_COLUMNS'($urandom);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default threshold: press after five samples, bounce clears the count
		repeat_row(3'd1, 8'h00, 5);
		repeat_row(3'd1, 8'hFF, 4);
		send_row(3'd1, 8'h00);

		// threshold of one: full rows, alternating columns, edge keys
		write_ticks(7'd1);
		send_row(3'd0, 8'h00);
		send_row(3'd0, 8'hFF);
		send_row(3'd7, 8'h55);
		send_row(3'd7, 8'hAA);
		send_row(3'd3, 8'h7F);
		send_row(3'd3, 8'hFE);
		send_row(3'd1, 8'hFF);

		// zero threshold acts on the first differing sample
		write_ticks(7'd0);
		send_row(3'd5, 8'hF0);
		send_row(3'd5, 8'h0F);
		send_row(3'd5, 8'h0F);

		// maximum threshold, then lowered while counts are running
		write_ticks(7'd127);
		repeat_row(3'd4, 8'hF0, 10);
		repeat_row(3'd2, 8'h00, 127);
		write_ticks(7'd2);
		send_row(3'd4, 8'hF0);

		// random scanning under several thresholds
		write_ticks(7'd3);
		scan_rows(70, 1'b1);
		write_ticks(7'd1);
		scan_rows(70, 1'b0);
		write_ticks(TICKS_W'($urandom_range(1, 6)));
		scan_rows(70, 1'b0);
		write_ticks(TICKS_W'($urandom_range(1, 6)));
		scan_rows(70, 1'b0);

		// closing stretch without any idling
		write_ticks(7'd2);
		wait_drained();
		idle_on = 1'b0;
		scan_rows(70, 1'b0);

		wait_drained();
		repeat (4 * HOLD_OFF) @(negedge clk);
		if (board.failures == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> key_matrix_debounce_scanner.f
rtl/core/kmds_pkg.sv
rtl/core/kmds_lane.sv
rtl/core/kmds_merge.sv
rtl/core/key_matrix_debounce_scanner.sv
rtl/core/kmds_checker.sv
test/key_matrix_debounce_scanner_test.sv
